// ----- rtl/core/ils_pkg.sv -----
package ils_pkg;

	// Store geometry and fixed field widths.
	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int LEN_W    = 7;
	localparam int MODE_W   = 3;
	localparam int POS_W    = 7;
	localparam int DATA_W   = 32;
	localparam int STAT_W   = 2;
	localparam int PLAN_W   = 2;

	typedef logic [MODE_W-1:0]        mode_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [STAT_W-1:0]        stat_code_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic [PLAN_W-1:0]        plan_t;

	// Command modes.
	localparam mode_t MODE_READ   = 3'd0;
	localparam mode_t MODE_HEAD   = 3'd1;
	localparam mode_t MODE_TAIL   = 3'd2;
	localparam mode_t MODE_INSERT = 3'd3;
	localparam mode_t MODE_DELETE = 3'd4;

	// Result status codes.
	localparam stat_code_t ST_DONE  = 2'd0;
	localparam stat_code_t ST_RANGE = 2'd1;
	localparam stat_code_t ST_FULL  = 2'd2;

	// Work planned for an accepted command.
	localparam plan_t PLAN_NONE = 2'd0;
	localparam plan_t PLAN_READ = 2'd1;
	localparam plan_t PLAN_UP   = 2'd2;
	localparam plan_t PLAN_DOWN = 2'd3;

	localparam len_t  CAP_LEN   = LEN_W'(CAPACITY);
	localparam data_t DATA_NEG1 = DATA_W'(-1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic rd_read;
		logic rd_up;
		logic rd_dn;
		logic wr_up;
		logic wr_dn;
		logic wr_place;
		logic dec_occ;
		logic load_rsp;
	} ils_ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		plan_t plan;
		logic  up_more;
		logic  dn_more;
	} ils_stat_t;

endpackage

// ----- rtl/core/ils_cmd_if.sv -----
interface ils_cmd_if;
	logic          valid;
	logic          ready;
	ils_pkg::mode_t mode;
	ils_pkg::pos_t  position;
	ils_pkg::data_t data_in;

	modport source (output valid, output mode, output position, output data_in, input ready);
	modport sink   (input valid, input mode, input position, input data_in, output ready);
endinterface

// ----- rtl/core/ils_rsp_if.sv -----
interface ils_rsp_if;
	logic               valid;
	logic               ready;
	ils_pkg::data_t      data_out;
	ils_pkg::stat_code_t status;
	ils_pkg::len_t       length;

	modport source (output valid, output data_out, output status, output length, input ready);
	modport sink   (input valid, input data_out, input status, input length, output ready);
endinterface

// ----- rtl/core/indexed_list_store_top.sv -----
// Channel   Role   Payload                          Transaction
// cmd       sink   mode, position, data_in          one list command
// rsp       source data_out, status, length         one result per command
//
// Each command is worked on alone until its result is registered. An insert at index p
// with n elements (head is p=0, tail is p=n) moves entries p..n-1 up, a delete at p moves
// the entries above p down, and reads and refused commands move none; the memory has one
// read and one write port, so each shifted entry costs a read and a write step. Reset
// clears only the size and handshake state, since entries at or above the size are never
// read. cmd stalls on rsp only when a second result is ready before the first is taken.
module indexed_list_store_top (
	input logic        clk,
	input logic        arst_n,
	ils_cmd_if.sink    cmd,
	ils_rsp_if.source  rsp
);
	import ils_pkg::*;

	ils_ctrl_t ctrl;
	ils_stat_t stat;

	// The controller sequences each command: plan, memory shift steps, final write or size
	// decrement, and the hand-off of the result into the output register.
	ils_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.out_ready(rsp.ready),
		.out_valid(rsp.valid),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// The datapath holds the size, the latched command, the element memory and
	// the result register.
	ils_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.stat    (stat),
		.mode    (cmd.mode),
		.position(cmd.position),
		.data_in (cmd.data_in),
		.data_out(rsp.data_out),
		.status  (rsp.status),
		.length  (rsp.length)
	);

endmodule

// ----- rtl/core/ils_ram.sv -----
module ils_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/core/ils_ctrl.sv -----
module ils_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               out_ready,
	output logic               out_valid,
	input  ils_pkg::ils_stat_t stat,
	output ils_pkg::ils_ctrl_t ctrl
);
	import ils_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PLAN  = 4'd1;
	localparam logic [3:0] S_READ  = 4'd2;
	localparam logic [3:0] S_UP_RD = 4'd3;
	localparam logic [3:0] S_UP_WR = 4'd4;
	localparam logic [3:0] S_PLACE = 4'd5;
	localparam logic [3:0] S_DN_RD = 4'd6;
	localparam logic [3:0] S_DN_WR = 4'd7;
	localparam logic [3:0] S_DEL   = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       rsp_valid_q;

	always_comb begin
		ctrl      = '0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctrl.latch = 1'b1;
					state_nxt  = S_PLAN;
				end
			end
			S_PLAN: begin
				unique case (stat.plan)
					PLAN_READ: state_nxt = S_READ;
					PLAN_UP:   state_nxt = S_UP_RD;
					PLAN_DOWN: state_nxt = S_DN_RD;
					default:   state_nxt = S_FIN;
				endcase
			end
			S_READ: begin
				ctrl.rd_read = 1'b1;
				state_nxt    = S_FIN;
			end
			S_UP_RD: begin
				if (stat.up_more) begin
					ctrl.rd_up = 1'b1;
					state_nxt  = S_UP_WR;
				end else begin
					state_nxt = S_PLACE;
				end
			end
			S_UP_WR: begin
				ctrl.wr_up = 1'b1;
				state_nxt  = S_UP_RD;
			end
			S_PLACE: begin
				ctrl.wr_place = 1'b1;
				state_nxt     = S_FIN;
			end
			S_DN_RD: begin
				if (stat.dn_more) begin
					ctrl.rd_dn = 1'b1;
					state_nxt  = S_DN_WR;
				end else begin
					state_nxt = S_DEL;
				end
			end
			S_DN_WR: begin
				ctrl.wr_dn = 1'b1;
				state_nxt  = S_DN_RD;
			end
			S_DEL: begin
				ctrl.dec_occ = 1'b1;
				state_nxt    = S_FIN;
			end
			S_FIN: begin
				if (!rsp_valid_q || out_ready) begin
					ctrl.load_rsp = 1'b1;
					state_nxt     = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctrl.load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (out_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = rsp_valid_q;

endmodule

// ----- rtl/core/ils_dpath.sv -----
module ils_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  ils_pkg::ils_ctrl_t  ctrl,
	output ils_pkg::ils_stat_t  stat,
	input  ils_pkg::mode_t      mode,
	input  ils_pkg::pos_t       position,
	input  ils_pkg::data_t      data_in,
	output ils_pkg::data_t      data_out,
	output ils_pkg::stat_code_t status,
	output ils_pkg::len_t       length
);
	import ils_pkg::*;

	len_t       occ_q;
	plan_t      plan_q;
	stat_code_t code_q;
	logic       neg1_q;
	len_t       tgt_q;
	len_t       cursor_q;
	data_t      val_q;
	data_t      data_out_q;
	stat_code_t status_q;
	len_t       length_q;

	plan_t      p_plan;
	stat_code_t p_code;
	logic       p_neg1;
	len_t       p_tgt;
	len_t       p_cur;
	logic       full;
	len_t       pos_len;
	len_t       cur_dec;
	len_t       cur_inc;

	logic                    ram_we;
	logic                    ram_re;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [DATA_W-1:0]       ram_wdata;
	logic [DATA_W-1:0]       ram_rdata;

	assign full    = (occ_q >= CAP_LEN);
	assign pos_len = LEN_W'(position);
	assign cur_dec = cursor_q - LEN_W'(1);
	assign cur_inc = cursor_q + LEN_W'(1);

	// Decide the work for the incoming command against the current size.
	always_comb begin
		p_plan = PLAN_NONE;
		p_code = ST_RANGE;
		p_neg1 = 1'b0;
		p_tgt  = pos_len;
		p_cur  = occ_q;
		unique case (mode)
			MODE_READ: begin
				if (pos_len < occ_q) begin
					p_plan = PLAN_READ;
					p_code = ST_DONE;
				end else begin
					p_neg1 = 1'b1;
				end
			end
			MODE_HEAD: begin
				p_tgt = '0;
				if (full) begin
					p_code = ST_FULL;
				end else begin
					p_plan = PLAN_UP;
					p_code = ST_DONE;
				end
			end
			MODE_TAIL: begin
				p_tgt = occ_q;
				if (full) begin
					p_code = ST_FULL;
				end else begin
					p_plan = PLAN_UP;
					p_code = ST_DONE;
				end
			end
			MODE_INSERT: begin
				if (pos_len > occ_q) begin
					p_code = ST_RANGE;
				end else if (full) begin
					p_code = ST_FULL;
				end else begin
					p_plan = PLAN_UP;
					p_code = ST_DONE;
				end
			end
			MODE_DELETE: begin
				p_cur = pos_len;
				if (pos_len < occ_q) begin
					p_plan = PLAN_DOWN;
					p_code = ST_DONE;
				end
			end
			default: p_code = ST_RANGE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (ctrl.wr_place) begin
			occ_q <= occ_q + LEN_W'(1);
		end else if (ctrl.dec_occ) begin
			occ_q <= occ_q - LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			plan_q   <= p_plan;
			code_q   <= p_code;
			neg1_q   <= p_neg1;
			tgt_q    <= p_tgt;
			cursor_q <= p_cur;
			val_q    <= data_in;
		end else if (ctrl.wr_up) begin
			cursor_q <= cur_dec;
		end else if (ctrl.wr_dn) begin
			cursor_q <= cur_inc;
		end
		if (ctrl.load_rsp) begin
			if (plan_q == PLAN_READ) begin
				data_out_q <= data_t'(ram_rdata);
			end else if (neg1_q) begin
				data_out_q <= DATA_NEG1;
			end else begin
				data_out_q <= '0;
			end
			status_q <= code_q;
			length_q <= occ_q;
		end
	end

	// Element memory: shifts go through it one entry per read and write pair.
	assign ram_re    = ctrl.rd_read | ctrl.rd_up | ctrl.rd_dn;
	assign ram_raddr = ctrl.rd_up ? cur_dec[ADDR_W-1:0] :
	                   ctrl.rd_dn ? cur_inc[ADDR_W-1:0] : tgt_q[ADDR_W-1:0];
	assign ram_we    = ctrl.wr_up | ctrl.wr_dn | ctrl.wr_place;
	assign ram_waddr = ctrl.wr_place ? tgt_q[ADDR_W-1:0] : cursor_q[ADDR_W-1:0];
	assign ram_wdata = ctrl.wr_place ? DATA_W'(val_q) : ram_rdata;

	ils_ram #(
		.WIDTH(DATA_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign stat.plan    = plan_q;
	assign stat.up_more = (cursor_q > tgt_q);
	assign stat.dn_more = (cur_inc < occ_q);

	assign data_out = data_out_q;
	assign status   = status_q;
	assign length   = length_q;

endmodule
